### rtl/ubdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubdc_pkg
// Widths, constants and the payload carried from cell to cell of the divider
// chains.
// ----------------------------------------------------------------------------
package ubdc_pkg;

  localparam int unsigned ClkW   = 32;
  localparam int unsigned BaudW  = 32;
  localparam int unsigned IntW   = 16;
  localparam int unsigned FracW  = 7;
  localparam int unsigned AchW   = 28;
  // Dividend of the first division: clock * 8.
  localparam int unsigned Num1W  = 35;
  // Dividend of the second division: clock * 4.
  localparam int unsigned Num2W  = 34;
  // Divisor of the second division: 64 * int + frac.
  localparam int unsigned DenW   = 23;

  localparam logic [IntW-1:0] IntMaxDiv = 16'hFFFF;
  localparam logic [6:0]      FracMask  = 7'h7F;

  // Operands and partial results riding alongside the chains.
  typedef struct packed {
    logic [ClkW-1:0]  clk_hz;
    logic [BaudW-1:0] baud;
    logic             zero_in;
  } ubdc_side_t;

  typedef struct packed {
    logic [ClkW-1:0]  clk_hz;
    logic [BaudW-1:0] baud;
    logic             zero_in;
    logic [IntW-1:0]  idiv;
    logic [FracW-1:0] fdiv;
  } ubdc_mid_t;

endpackage

### rtl/ubdc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubdc_stream_if
// Valid/ready channel carrying a payload of selectable type.
// ----------------------------------------------------------------------------
interface ubdc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/ubdc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubdc_div_cell
// One restoring-division cell: resolves one quotient bit and hands the
// partial remainder and operands to the next cell.
// ----------------------------------------------------------------------------
module ubdc_div_cell #(
  parameter int unsigned NumW  = 35,
  parameter int unsigned DenWd = 32,
  parameter int unsigned BitIx = 0,
  parameter type         side_t = logic
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DenWd:0]   in_rem,
  input  logic [NumW-1:0]  in_num,
  input  logic [NumW-1:0]  in_quo,
  input  logic [DenWd-1:0] in_den,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [DenWd:0]   out_rem,
  output logic [NumW-1:0]  out_num,
  output logic [NumW-1:0]  out_quo,
  output logic [DenWd-1:0] out_den,
  output side_t            out_side
);

  logic             vld_r;
  logic [DenWd:0]   rem_r, rem_nxt;
  logic [NumW-1:0]  num_r, quo_r, quo_nxt;
  logic [DenWd-1:0] den_r;
  side_t            side_r;
  logic [DenWd+1:0] shifted;
  logic [DenWd+1:0] diff;

  always_comb begin
    shifted = {in_rem, in_num[BitIx]};
    diff    = shifted - {2'b00, in_den};
    quo_nxt = in_quo;
    if (!diff[DenWd+1]) begin
      rem_nxt        = diff[DenWd:0];
      quo_nxt[BitIx] = 1'b1;
    end else begin
      rem_nxt = shifted[DenWd:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      num_r  <= in_num;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_num  = num_r;
  assign out_quo  = quo_r;
  assign out_den  = den_r;
  assign out_side = side_r;

endmodule

### rtl/ubdc_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubdc_div_chain
// Row of division cells, one quotient bit per cell, most significant first.
// ----------------------------------------------------------------------------
module ubdc_div_chain #(
  parameter int unsigned NumW  = 35,
  parameter int unsigned DenWd = 32,
  parameter type         side_t = logic
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NumW-1:0]  in_num,
  input  logic [DenWd-1:0] in_den,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [NumW-1:0]  out_quo,
  output side_t            out_side
);

  logic             vld [NumW+1];
  logic [DenWd:0]   rem [NumW+1];
  logic [NumW-1:0]  num [NumW+1];
  logic [NumW-1:0]  quo [NumW+1];
  logic [DenWd-1:0] den [NumW+1];
  side_t            side [NumW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = '0;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    ubdc_div_cell #(
      .NumW(NumW), .DenWd(DenWd), .BitIx(NumW-1-g), .side_t(side_t)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(vld[g]), .in_rem(rem[g]), .in_num(num[g]), .in_quo(quo[g]),
      .in_den(den[g]), .in_side(side[g]),
      .out_vld(vld[g+1]), .out_rem(rem[g+1]), .out_num(num[g+1]),
      .out_quo(quo[g+1]), .out_den(den[g+1]), .out_side(side[g+1])
    );
  end

  assign out_vld  = vld[NumW];
  assign out_quo  = quo[NumW];
  assign out_side = side[NumW];

endmodule

### rtl/uart_baud_divisor_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_check
// Fractional UART divisor from clock and requested baud, with achieved rate
// and a one-percent tolerance flag.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      sink       requested_baud (32)
//  out_     source     integer_divisor, fraction_divisor, achieved_baud,
//                      within_tolerance
//  cfg_     write      clock_hz (32)
//
// One beat enters per cycle while the pipe advances. The pipe holds two
// chains of division cells (35 and 34 cells), a clamp stage and the output
// register, which also takes the tolerance check. The whole pipe advances
// when the output register is empty or being taken, so a stall downstream
// holds every stage.
// Reset is synchronous and clears all valid bits and clock_hz.
// ----------------------------------------------------------------------------
module uart_baud_divisor_check
  import ubdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ClkW-1:0]     cfg_wdata,
  ubdc_stream_if.sink         in_ch,
  ubdc_stream_if.source       out_ch
);

  typedef struct packed {
    logic [IntW-1:0]  integer_divisor;
    logic [FracW-1:0] fraction_divisor;
    logic [AchW-1:0]  achieved_baud;
    logic             within_tolerance;
  } res_t;

  logic [ClkW-1:0] clock_hz_r;
  logic            en;
  logic            out_vld_r;
  res_t            res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= '0;
    end else if (cfg_we) begin
      clock_hz_r <= cfg_wdata;
    end
  end

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // First chain: q = clock*8 / baud.
  ubdc_side_t s0, s1;
  logic       v1;
  logic [Num1W-1:0] q1;

  assign s0.clk_hz  = clock_hz_r;
  assign s0.baud    = in_ch.data;
  assign s0.zero_in = (clock_hz_r == '0) || (in_ch.data == '0);

  ubdc_div_chain #(.NumW(Num1W), .DenWd(BaudW), .side_t(ubdc_side_t)) u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_ch.valid), .in_num({clock_hz_r, 3'b000}),
    .in_den((in_ch.data == '0) ? {{(BaudW-1){1'b0}}, 1'b1} : in_ch.data),
    .in_side(s0), .out_vld(v1), .out_quo(q1), .out_side(s1)
  );

  // Clamp stage.
  logic [31:0]     q32;
  logic [24:0]     ipart;
  ubdc_mid_t       mid_r, mid_nxt;
  logic            mid_vld_r;

  always_comb begin
    q32             = q1[31:0];
    ipart           = q32[31:7];
    mid_nxt.clk_hz  = s1.clk_hz;
    mid_nxt.baud    = s1.baud;
    mid_nxt.zero_in = s1.zero_in;
    if (ipart == '0) begin
      mid_nxt.idiv = 16'd1;
      mid_nxt.fdiv = '0;
    end else if (ipart >= {9'd0, IntMaxDiv}) begin
      mid_nxt.idiv = IntMaxDiv;
      mid_nxt.fdiv = '0;
    end else begin
      mid_nxt.idiv = ipart[IntW-1:0];
      mid_nxt.fdiv = FracW'(({1'b0, q32[6:0] & FracMask} + 8'd1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else if (en) begin
      mid_vld_r <= v1;
    end
    if (en) begin
      mid_r <= mid_nxt;
    end
  end

  // Second chain: achieved = clock*4 / (64*int + frac).
  logic [DenW-1:0]  den2;
  logic             v2;
  logic [Num2W-1:0] q2;
  ubdc_mid_t        s2;

  assign den2 = {1'b0, mid_r.idiv, 6'd0} + {{(DenW-FracW){1'b0}}, mid_r.fdiv};

  ubdc_div_chain #(.NumW(Num2W), .DenWd(DenW), .side_t(ubdc_mid_t)) u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(mid_vld_r), .in_num({mid_r.clk_hz, 2'b00}), .in_den(den2),
    .in_side(mid_r), .out_vld(v2), .out_quo(q2), .out_side(s2)
  );

  // Tolerance stage: |achieved - baud| * 100 <= baud.
  logic [31:0] ach32;
  logic [31:0] diff;
  logic [38:0] diff100;

  always_comb begin
    ach32   = q2[31:0];
    diff    = (ach32 > s2.baud) ? (ach32 - s2.baud) : (s2.baud - ach32);
    diff100 = {1'b0, diff, 6'd0} + {2'b00, diff, 5'd0} + {5'b0, diff, 2'b00};
    res_nxt = '0;
    if (!s2.zero_in) begin
      res_nxt.integer_divisor  = s2.idiv;
      res_nxt.fraction_divisor = s2.fdiv;
      res_nxt.achieved_baud    = ach32[AchW-1:0];
      res_nxt.within_tolerance = (ach32 != '0) && (diff100 <= {7'd0, s2.baud});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v2;
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = {res_r.integer_divisor, res_r.fraction_divisor,
                         res_r.achieved_baud, res_r.within_tolerance};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(res_r))
    else $error("result changed under stall");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.fraction_divisor <= 7'd64)
    else $error("fraction above 64");
  a_clamp_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.integer_divisor == IntMaxDiv |-> res_r.fraction_divisor == '0)
    else $error("clamped divisor with fraction");

endmodule

### tb/uart_baud_divisor_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_check_tb
// Self-checking bench for the fractional baud divisor block. Requested rates
// stream in under random gaps and receiver stalls. Every result beat is
// compared field by field with a divisor predicted in the bench. The clock
// register is changed between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
module uart_baud_divisor_check_tb
  import ubdc_pkg::*;
();

  typedef struct packed {
    logic [IntW-1:0]  integer_divisor;
    logic [FracW-1:0] fraction_divisor;
    logic [AchW-1:0]  achieved_baud;
    logic             within_tolerance;
  } divisor_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 80;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [ClkW-1:0] cfg_wdata;

  ubdc_stream_if #(.payload_t(logic [BaudW-1:0])) in_ch ();
  ubdc_stream_if #(.payload_t(divisor_t))         out_ch ();

  uart_baud_divisor_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [ClkW-1:0] clock_setting;
  divisor_t        pending_divisors[$];
  int unsigned     errors;
  int unsigned     cycles;
  bit              calm;
  bit              hold_req;
  bit              hold_seen;
  int unsigned     hold_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d beats outstanding", $time, pending_divisors.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic divisor_t predict_divisor(logic [ClkW-1:0] hz, logic [BaudW-1:0] baud);
    divisor_t    r;
    logic [63:0] q;
    logic [31:0] q32;
    logic [31:0] idiv;
    logic [31:0] fdiv;
    logic [63:0] denom;
    logic [63:0] ach;
    logic [63:0] diff;
    r = '0;
    if (hz == 0 || baud == 0) return r;
    q = ({32'd0, hz} * 64'd8) / {32'd0, baud};
    q32 = q[31:0];
    idiv = q32 >> 7;
    if (idiv == 0) begin
      idiv = 1;
      fdiv = 0;
    end else if (idiv >= 32'd65535) begin
      idiv = 65535;
      fdiv = 0;
    end else begin
      fdiv = ((q32 & 32'h7F) + 1) / 2;
    end
    denom = 64'd64 * idiv + fdiv;
    ach = (({32'd0, hz} * 64'd4) / denom) & 64'hFFFF_FFFF;
    diff = (ach > baud) ? ach - baud : baud - ach;
    r.integer_divisor  = idiv[IntW-1:0];
    r.fraction_divisor = fdiv[FracW-1:0];
    r.achieved_baud    = ach[AchW-1:0];
    r.within_tolerance = (ach != 0) && (diff * 100 <= baud);
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    divisor_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_divisors.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $time, out_ch.data);
          errors = errors + 1;
        end else begin
          want = pending_divisors.pop_front();
          if (want.integer_divisor !== out_ch.data.integer_divisor) begin
            $display("%0t integer_divisor: expected %0d actual %0d", $time,
                     want.integer_divisor, out_ch.data.integer_divisor);
            errors = errors + 1;
          end
          if (want.fraction_divisor !== out_ch.data.fraction_divisor) begin
            $display("%0t fraction_divisor: expected %0d actual %0d", $time,
                     want.fraction_divisor, out_ch.data.fraction_divisor);
            errors = errors + 1;
          end
          if (want.achieved_baud !== out_ch.data.achieved_baud) begin
            $display("%0t achieved_baud: expected %0d actual %0d", $time,
                     want.achieved_baud, out_ch.data.achieved_baud);
            errors = errors + 1;
          end
          if (want.within_tolerance !== out_ch.data.within_tolerance) begin
            $display("%0t within_tolerance: expected %0d actual %0d", $time,
                     want.within_tolerance, out_ch.data.within_tolerance);
            errors = errors + 1;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_baud(logic [BaudW-1:0] baud);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= baud;
    do @(posedge clk); while (!in_ch.ready);
    pending_divisors.push_back(predict_divisor(clock_setting, baud));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_clock(logic [ClkW-1:0] hz);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clock_setting = hz;
    @(posedge clk);
  endtask

  function automatic logic [BaudW-1:0] random_baud();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(4000000, 300);
      2: return $urandom >> $urandom_range(31);
      default: return clock_setting / (16 * $urandom_range(70000, 1));
    endcase
  endfunction

  task automatic test_reset_clock();
    // Register is still zero after reset: every answer is all zeros.
    send_baud(32'd115200);
    send_baud(32'd0);
    send_baud(32'hFFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_directed();
    set_clock(32'd48_000_000);
    send_baud(32'd0);
    send_baud(32'd9600);
    send_baud(32'd115200);
    send_baud(32'd3_000_000);      // exactly clock/16
    send_baud(32'd3_000_001);      // integer part zero, clamps to one
    send_baud(32'hFFFF_FFFF);
    send_baud(32'd1);              // integer part far above the upper clamp
    send_baud(32'd45);             // integer part just above the upper clamp
    send_baud(32'd46);
    drain_pipe();
    set_clock(32'hFFFF_FFFF);
    send_baud(32'd1);
    send_baud(32'd2);
    send_baud(32'hFFFF_FFFF);
    send_baud(32'h8000_0000);
    send_baud(32'd921600);
    drain_pipe();
    // Slow clock: divisor given for nonzero rates, achieved rate rounds down to zero.
    set_clock(32'd1);
    send_baud(32'd1);
    send_baud(32'hFFFF_FFFF);
    send_baud(32'd0);
    drain_pipe();
  endtask

  task automatic test_random(logic [ClkW-1:0] hz, int unsigned n, bit quiet, bit stall);
    set_clock(hz);
    calm = quiet;
    for (int unsigned i = 0; i < n; i++) begin
      if (stall && i == 20) hold_req = ~hold_req;
      send_baud(random_baud());
    end
    calm = 1'b0;
    drain_pipe();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    clock_setting = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_clock();
    test_directed();
    test_random(32'd50_000_000, 400, 1'b0, 1'b1);
    test_random(32'd1_843_200, 300, 1'b1, 1'b0);
    test_random(32'hFFFF_FFFF, 300, 1'b0, 1'b0);
    test_random($urandom, 350, 1'b0, 1'b1);
    test_random($urandom_range(1000, 1), 200, 1'b0, 1'b0);
    test_random(32'd0, 50, 1'b0, 1'b0);
    test_random($urandom, 350, 1'b0, 1'b0);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### uart_baud_divisor_check.f
rtl/ubdc_pkg.sv
rtl/ubdc_stream_if.sv
rtl/ubdc_div_cell.sv
rtl/ubdc_div_chain.sv
rtl/uart_baud_divisor_check.sv
tb/uart_baud_divisor_check_tb.sv
